// ----- sv/wpt_pkg.sv -----
// Shared types and constants of the waypoint turn filter.
`timescale 1ns / 1ps

package wpt_pkg;

	localparam int FRAC_BITS = 16;
	localparam int COORD_W   = 32;
	localparam int HLIM_W    = 31;
	localparam int TLIM_W    = 17;
	localparam int CFG_W     = 31;
	localparam int QPTR_W    = 2;
	localparam int QDEPTH    = 1 << QPTR_W;

	localparam logic [HLIM_W-1:0] HLIM_RESET = HLIM_W'(((5 << FRAC_BITS) + 50) / 100);
	localparam logic [TLIM_W-1:0] TLIM_RESET = 17'd65316;
	localparam logic [TLIM_W-1:0] TURN_HALF  = 17'd32768;

	// Configuration register indexes
	localparam logic CFG_HEIGHT = 1'b0;
	localparam logic CFG_TURN   = 1'b1;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} point_t;

	typedef enum logic {
		CMD_FEED,
		CMD_FINISH
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t op;
		point_t  pt;
	} cmd_t;

endpackage

// ----- sv/wpt_front.sv -----
// Front end: accepts waypoints, runs the height seam test and issues commands.
`timescale 1ns / 1ps

module wpt_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  wpt_pkg::point_t               in_pt,
	input  logic                          in_last,
	input  logic [wpt_pkg::HLIM_W-1:0]    height_limit,
	output logic                          q_push,
	output wpt_pkg::cmd_t                 q_cmd,
	input  logic                          q_full
);

	typedef enum logic [2:0] {
		F_IDLE,
		F_DOT,
		F_FEED,
		F_TAIL,
		F_FIN
	} fstate_t;

	fstate_t          state_q;
	wpt_pkg::point_t  w0_q, w3_q, cur_q;
	logic [1:0]       cnt_q;
	logic             pend_q;
	logic             last_q;
	logic             drop_q;
	logic [1:0]       k_q;
	logic signed [65:0] prod_q;
	logic signed [67:0] acc_q;

	logic signed [32:0] zd;
	logic [32:0]        zmag;
	logic               hstep;
	logic signed [32:0] da, db;
	logic signed [65:0] prod_d;
	logic signed [67:0] dot_fin;
	logic               tail_feed;
	logic               want;

	// Height step between the two held points
	assign zd    = $signed({w0_q.z[31], w0_q.z}) - $signed({w3_q.z[31], w3_q.z});
	assign zmag  = zd[32] ? 33'(-zd) : zd;
	assign hstep = zmag > {2'b00, height_limit};

	// Select one component of both segments for the reversal dot product
	always_comb begin
		case (k_q)
			2'd0: begin
				da = $signed({w3_q.x[31], w3_q.x}) - $signed({w0_q.x[31], w0_q.x});
				db = $signed({cur_q.x[31], cur_q.x}) - $signed({w3_q.x[31], w3_q.x});
			end
			2'd1: begin
				da = $signed({w3_q.y[31], w3_q.y}) - $signed({w0_q.y[31], w0_q.y});
				db = $signed({cur_q.y[31], cur_q.y}) - $signed({w3_q.y[31], w3_q.y});
			end
			default: begin
				da = $signed({w3_q.z[31], w3_q.z}) - $signed({w0_q.z[31], w0_q.z});
				db = $signed({cur_q.z[31], cur_q.z}) - $signed({w3_q.z[31], w3_q.z});
			end
		endcase
	end

	assign prod_d  = da * db;
	assign dot_fin = acc_q + {{2{prod_q[65]}}, prod_q};

	assign tail_feed = (cnt_q == 2'd2) && !pend_q && !hstep;
	assign in_stall  = (state_q != F_IDLE);

	// Command towards the queue
	always_comb begin
		want     = 1'b0;
		q_cmd.op = wpt_pkg::CMD_FEED;
		q_cmd.pt = w3_q;
		case (state_q)
			F_FEED: want = !drop_q;
			F_TAIL: want = tail_feed;
			F_FIN: begin
				want     = 1'b1;
				q_cmd.op = wpt_pkg::CMD_FINISH;
			end
			default: want = 1'b0;
		endcase
	end

	assign q_push = want && !q_full;

	// Seam stage sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q   <= 2'd0;
			pend_q  <= 1'b0;
			last_q  <= 1'b0;
			drop_q  <= 1'b0;
			k_q     <= 2'd0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (in_valid) begin
						cur_q  <= in_pt;
						last_q <= in_last;
						if (cnt_q == 2'd0) begin
							w3_q    <= in_pt;
							pend_q  <= 1'b0;
							cnt_q   <= 2'd1;
							state_q <= in_last ? F_TAIL : F_IDLE;
						end else if (cnt_q == 2'd1 || pend_q || !hstep) begin
							drop_q  <= 1'b0;
							state_q <= F_FEED;
						end else begin
							k_q     <= 2'd0;
							acc_q   <= '0;
							state_q <= F_DOT;
						end
					end
				end
				F_DOT: begin
					if (k_q != 2'd3)
						prod_q <= prod_d;
					if (k_q != 2'd0)
						acc_q <= dot_fin;
					if (k_q == 2'd3) begin
						drop_q  <= dot_fin[67] || (dot_fin == '0);
						state_q <= F_FEED;
					end
					k_q <= k_q + 2'd1;
				end
				F_FEED: begin
					if (drop_q || !q_full) begin
						w0_q    <= w3_q;
						w3_q    <= cur_q;
						pend_q  <= drop_q;
						cnt_q   <= 2'd2;
						state_q <= last_q ? F_TAIL : F_IDLE;
					end
				end
				F_TAIL: begin
					if (!tail_feed || !q_full)
						state_q <= F_FIN;
				end
				F_FIN: begin
					if (!q_full) begin
						cnt_q   <= 2'd0;
						pend_q  <= 1'b0;
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

endmodule

// ----- sv/wpt_queue.sv -----
// Short command queue between the front end and the turn stage.
`timescale 1ns / 1ps

module wpt_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  wpt_pkg::cmd_t  push_cmd,
	output logic           full,
	input  logic           pop,
	output logic           valid,
	output wpt_pkg::cmd_t  head
);

	wpt_pkg::cmd_t               mem_q [wpt_pkg::QDEPTH];
	logic [wpt_pkg::QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [wpt_pkg::QPTR_W:0]    cnt_q;

	assign full  = (cnt_q == (wpt_pkg::QPTR_W+1)'(wpt_pkg::QDEPTH));
	assign valid = (cnt_q != '0);
	assign head  = mem_q[rd_ptr_q];

	// Store items
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_cmd;
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ----- sv/wpt_back.sv -----
// Turn stage: exact turn-cosine test on a shared multiplier and result register.
`timescale 1ns / 1ps

module wpt_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_valid,
	input  wpt_pkg::cmd_t               q_cmd,
	output logic                        q_pop,
	input  logic [wpt_pkg::TLIM_W-1:0]  turn_limit,
	output logic                        out_valid,
	input  logic                        out_stall,
	output wpt_pkg::point_t             out_pt,
	output logic                        out_fin,
	output logic                        out_empty
);

	typedef enum logic [2:0] {
		B_IDLE,
		B_NORM,
		B_DECIDE,
		B_BIG,
		B_NEXT,
		B_EMIT
	} bstate_t;

	bstate_t            state_q;
	wpt_pkg::point_t    t0_q, t3_q, s_q;
	logic [1:0]         tc_q;
	logic [3:0]         k_q;
	logic signed [67:0] prod_q;
	logic [65:0]        na_q, nb_q;
	logic signed [66:0] dot_q;
	logic [1:0]         mstep_q;
	logic [1:0]         i_q, j_q, ilast_q, jlast_q;
	logic               iss_q, pv_q;
	logic [2:0]         sh_q;
	logic [191:0]       acc_q, r_q;
	logic [127:0]       x_q, y_q;
	wpt_pkg::point_t    em_pt_q;
	logic               em_fin_q, em_empty_q;
	logic               out_valid_q;
	wpt_pkg::point_t    out_pt_q;
	logic               out_fin_q, out_empty_q;

	logic [1:0]         comp;
	logic signed [32:0] da, db;
	logic signed [33:0] opa, opb;
	logic signed [67:0] mul;
	logic [191:0]       addend;
	logic               za, zb;
	logic               out_free;

	// Component and operand choice for the norm and dot products
	always_comb begin
		case (k_q) inside
			4'd0, 4'd3, 4'd6: comp = 2'd0;
			4'd1, 4'd4, 4'd7: comp = 2'd1;
			default:          comp = 2'd2;
		endcase
	end

	always_comb begin
		case (comp)
			2'd0: begin
				da = $signed({t3_q.x[31], t3_q.x}) - $signed({t0_q.x[31], t0_q.x});
				db = $signed({s_q.x[31], s_q.x}) - $signed({t3_q.x[31], t3_q.x});
			end
			2'd1: begin
				da = $signed({t3_q.y[31], t3_q.y}) - $signed({t0_q.y[31], t0_q.y});
				db = $signed({s_q.y[31], s_q.y}) - $signed({t3_q.y[31], t3_q.y});
			end
			default: begin
				da = $signed({t3_q.z[31], t3_q.z}) - $signed({t0_q.z[31], t0_q.z});
				db = $signed({s_q.z[31], s_q.z}) - $signed({t3_q.z[31], t3_q.z});
			end
		endcase
	end

	// Shared multiplier: segment components or 32-bit limbs
	always_comb begin
		if (state_q == B_BIG) begin
			opa = $signed({2'b00, x_q[32*i_q +: 32]});
			opb = $signed({2'b00, y_q[32*j_q +: 32]});
		end else begin
			opa = (k_q < 4'd3 || k_q > 4'd5) ? {da[32], da} : {db[32], db};
			opb = (k_q < 4'd6) ? opa : {db[32], db};
		end
	end

	assign mul    = opa * opb;
	assign addend = {128'b0, prod_q[63:0]} << {sh_q, 5'b0};

	assign za       = (na_q == '0);
	assign zb       = (nb_q == '0);
	assign out_free = !out_valid_q || !out_stall;
	assign q_pop    = (state_q == B_IDLE) && q_valid;

	assign out_valid = out_valid_q;
	assign out_pt    = out_pt_q;
	assign out_fin   = out_fin_q;
	assign out_empty = out_empty_q;

	// Result register
	always_ff @(posedge clk) begin
		if (state_q == B_EMIT && out_free) begin
			out_pt_q    <= em_pt_q;
			out_fin_q   <= em_fin_q;
			out_empty_q <= em_empty_q;
		end
	end

	// Turn stage sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			tc_q        <= 2'd0;
			k_q         <= 4'd0;
			mstep_q     <= 2'd0;
			iss_q       <= 1'b0;
			pv_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == B_EMIT && out_free)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;

			unique case (state_q)
				B_IDLE: begin
					if (q_valid) begin
						s_q <= q_cmd.pt;
						if (q_cmd.op == wpt_pkg::CMD_FINISH) begin
							em_pt_q    <= (tc_q == 2'd0) ? '0 : t3_q;
							em_fin_q   <= 1'b1;
							em_empty_q <= (tc_q == 2'd0);
							tc_q       <= 2'd0;
							state_q    <= B_EMIT;
						end else if (tc_q == 2'd0) begin
							t3_q <= q_cmd.pt;
							tc_q <= 2'd1;
						end else if (tc_q == 2'd1) begin
							em_pt_q    <= t3_q;
							em_fin_q   <= 1'b0;
							em_empty_q <= 1'b0;
							t0_q       <= t3_q;
							t3_q       <= q_cmd.pt;
							tc_q       <= 2'd2;
							state_q    <= B_EMIT;
						end else begin
							k_q     <= 4'd0;
							na_q    <= '0;
							nb_q    <= '0;
							dot_q   <= '0;
							state_q <= B_NORM;
						end
					end
				end
				B_NORM: begin
					if (k_q != 4'd9)
						prod_q <= mul;
					if (k_q >= 4'd1 && k_q <= 4'd3)
						na_q <= na_q + prod_q[65:0];
					else if (k_q >= 4'd4 && k_q <= 4'd6)
						nb_q <= nb_q + prod_q[65:0];
					else if (k_q >= 4'd7)
						dot_q <= dot_q + prod_q[66:0];
					if (k_q == 4'd9)
						state_q <= B_DECIDE;
					k_q <= k_q + 4'd1;
				end
				B_DECIDE: begin
					em_pt_q    <= t3_q;
					em_fin_q   <= 1'b0;
					em_empty_q <= 1'b0;
					if (za || zb || dot_q[66]) begin
						t0_q <= t3_q;
						t3_q <= s_q;
						if (za && zb)
							state_q <= B_IDLE;
						else if (za || zb)
							state_q <= (turn_limit > wpt_pkg::TURN_HALF) ? B_EMIT : B_IDLE;
						else
							state_q <= B_EMIT;
					end else begin
						// Limit squared first
						x_q     <= {111'b0, turn_limit};
						y_q     <= {111'b0, turn_limit};
						ilast_q <= 2'd0;
						jlast_q <= 2'd0;
						mstep_q <= 2'd0;
						i_q     <= 2'd0;
						j_q     <= 2'd0;
						acc_q   <= '0;
						iss_q   <= 1'b1;
						pv_q    <= 1'b0;
						state_q <= B_BIG;
					end
				end
				B_BIG: begin
					// Issue one limb product and accumulate the previous one
					if (iss_q) begin
						prod_q <= mul;
						sh_q   <= {1'b0, i_q} + {1'b0, j_q};
						pv_q   <= 1'b1;
						if (j_q == jlast_q) begin
							j_q <= 2'd0;
							i_q <= i_q + 2'd1;
							if (i_q == ilast_q)
								iss_q <= 1'b0;
						end else begin
							j_q <= j_q + 2'd1;
						end
					end else begin
						pv_q <= 1'b0;
					end
					if (pv_q)
						acc_q <= acc_q + addend;
					if (!iss_q && pv_q)
						state_q <= B_NEXT;
				end
				B_NEXT: begin
					i_q     <= 2'd0;
					j_q     <= 2'd0;
					iss_q   <= 1'b1;
					pv_q    <= 1'b0;
					acc_q   <= '0;
					mstep_q <= mstep_q + 2'd1;
					state_q <= B_BIG;
					case (mstep_q)
						2'd0: begin
							x_q     <= {94'b0, acc_q[33:0]};
							y_q     <= {62'b0, na_q};
							ilast_q <= 2'd1;
							jlast_q <= 2'd2;
						end
						2'd1: begin
							x_q     <= acc_q[127:0];
							y_q     <= {62'b0, nb_q};
							ilast_q <= 2'd3;
							jlast_q <= 2'd2;
						end
						2'd2: begin
							r_q     <= acc_q;
							x_q     <= {62'b0, dot_q[65:0]};
							y_q     <= {62'b0, dot_q[65:0]};
							ilast_q <= 2'd2;
							jlast_q <= 2'd2;
						end
						default: begin
							// dot squared times 2^32 against limit^2 * |a|^2 * |b|^2
							iss_q   <= 1'b0;
							t0_q    <= t3_q;
							t3_q    <= s_q;
							state_q <= ({acc_q[159:0], 32'b0} < r_q) ? B_EMIT : B_IDLE;
						end
					endcase
				end
				B_EMIT: begin
					if (out_free)
						state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule

// ----- sv/waypoint_turn_filter.sv -----
// Waypoint turn filter: takes 3-D waypoints, one item per route point, and returns turning points.
// Front end: height seam test per item; may also run the reversal dot product on a height step above the limit.
// Turn stage: the norm and dot products, then, unless a norm is zero or the dot is negative,
// the exact squared cosine compare runs its limb products on the one shared multiplier.
// Throughput: one item at a time in the front end; a 4-entry queue lets it run ahead.
// Reset: asynchronous, active low; empties both windows and the queue, clears result valid; limits take defaults.
`timescale 1ns / 1ps

module waypoint_turn_filter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [31:0]            x_pos,
	input  logic signed [31:0]            y_pos,
	input  logic signed [31:0]            z_pos,
	input  logic                          route_end,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [31:0]            kept_x,
	output logic signed [31:0]            kept_y,
	output logic signed [31:0]            kept_z,
	output logic                          final_point,
	output logic                          route_empty,
	input  logic                          cfg_write,
	input  logic                          cfg_index,
	input  logic [wpt_pkg::CFG_W-1:0]     cfg_data
);

	logic [wpt_pkg::HLIM_W-1:0] height_limit_q;
	logic [wpt_pkg::TLIM_W-1:0] turn_limit_q;
	wpt_pkg::point_t            in_pt;
	wpt_pkg::point_t            out_pt;
	wpt_pkg::cmd_t              push_cmd, head;
	logic                       q_push, q_full, q_pop, q_valid;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_limit_q <= wpt_pkg::HLIM_RESET;
			turn_limit_q   <= wpt_pkg::TLIM_RESET;
		end else if (cfg_write) begin
			if (cfg_index == wpt_pkg::CFG_HEIGHT)
				height_limit_q <= cfg_data[wpt_pkg::HLIM_W-1:0];
			else
				turn_limit_q <= cfg_data[wpt_pkg::TLIM_W-1:0];
		end
	end

	assign in_pt.x = x_pos;
	assign in_pt.y = y_pos;
	assign in_pt.z = z_pos;

	wpt_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_pt        (in_pt),
		.in_last      (route_end),
		.height_limit (height_limit_q),
		.q_push       (q_push),
		.q_cmd        (push_cmd),
		.q_full       (q_full)
	);

	wpt_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.valid    (q_valid),
		.head     (head)
	);

	wpt_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_cmd      (head),
		.q_pop      (q_pop),
		.turn_limit (turn_limit_q),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_pt     (out_pt),
		.out_fin    (final_point),
		.out_empty  (route_empty)
	);

	assign kept_x = out_pt.x;
	assign kept_y = out_pt.y;
	assign kept_z = out_pt.z;

	// The queue is never written when full and never read when empty
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full) else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("queue read while empty");

	// A route end always takes the front end through its finish step
	a_end_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && route_end) |=> in_stall)
		else $error("route end accepted without finish step");

	// An empty route result is always the last one and carries zero x and z coordinates
	a_empty_final: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && route_empty) |-> (final_point && kept_x == '0 && kept_z == '0))
		else $error("empty route result malformed");

endmodule
